FILE: hw/rtl/jhd_pkg.sv
// shared types, codes and the zigzag table for the jpeg huffman block decoder
// no dependencies
package jhd_pkg;

	localparam int BLOCK_SIZE = 64;

	localparam logic [1:0] MODE_COUNT   = 2'd0;
	localparam logic [1:0] MODE_SYMBOL  = 2'd1;
	localparam logic [1:0] MODE_DATA    = 2'd2;
	localparam logic [1:0] MODE_RESTART = 2'd3;

	localparam logic [2:0] KIND_COEFF   = 3'd0;
	localparam logic [2:0] KIND_CLOSE   = 3'd1;
	localparam logic [2:0] KIND_EOB     = 3'd2;
	localparam logic [2:0] KIND_NOMATCH = 3'd3;
	localparam logic [2:0] KIND_OVERRUN = 3'd4;

	localparam logic [16:0] NO_CODE = 17'h10000;

	typedef enum logic [1:0] {
		PH_DC_SYM = 2'd0,
		PH_DC_VAL = 2'd1,
		PH_AC_SYM = 2'd2,
		PH_AC_VAL = 2'd3
	} phase_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       table_sel;
		logic [7:0] slot_index;
		logic [7:0] payload;
	} item_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [5:0]         position;
		logic signed [15:0] coeff_value;
		logic               last_of_item;
	} result_t;

	typedef struct packed {
		logic       wr_count;
		logic       wr_symbol;
		logic       restart;
		logic       load_byte;
		logic       bit_step;
		logic       look_step;
		logic       build_step;
		logic [4:0] build_k;
		logic       flush;
	} dp_cmd_t;

	typedef struct packed {
		logic matched;
		logic pend_valid;
		logic out_free;
	} dp_stat_t;

	function automatic logic [5:0] natural_of(input logic [5:0] zz);
		logic [5:0] n;
		case (zz)
			6'd0: n = 6'd0;   6'd1: n = 6'd1;   6'd2: n = 6'd8;   6'd3: n = 6'd16;
			6'd4: n = 6'd9;   6'd5: n = 6'd2;   6'd6: n = 6'd3;   6'd7: n = 6'd10;
			6'd8: n = 6'd17;  6'd9: n = 6'd24;  6'd10: n = 6'd32; 6'd11: n = 6'd25;
			6'd12: n = 6'd18; 6'd13: n = 6'd11; 6'd14: n = 6'd4;  6'd15: n = 6'd5;
			6'd16: n = 6'd12; 6'd17: n = 6'd19; 6'd18: n = 6'd26; 6'd19: n = 6'd33;
			6'd20: n = 6'd40; 6'd21: n = 6'd48; 6'd22: n = 6'd41; 6'd23: n = 6'd34;
			6'd24: n = 6'd27; 6'd25: n = 6'd20; 6'd26: n = 6'd13; 6'd27: n = 6'd6;
			6'd28: n = 6'd7;  6'd29: n = 6'd14; 6'd30: n = 6'd21; 6'd31: n = 6'd28;
			6'd32: n = 6'd35; 6'd33: n = 6'd42; 6'd34: n = 6'd49; 6'd35: n = 6'd56;
			6'd36: n = 6'd57; 6'd37: n = 6'd50; 6'd38: n = 6'd43; 6'd39: n = 6'd36;
			6'd40: n = 6'd29; 6'd41: n = 6'd22; 6'd42: n = 6'd15; 6'd43: n = 6'd23;
			6'd44: n = 6'd30; 6'd45: n = 6'd37; 6'd46: n = 6'd44; 6'd47: n = 6'd51;
			6'd48: n = 6'd58; 6'd49: n = 6'd59; 6'd50: n = 6'd52; 6'd51: n = 6'd45;
			6'd52: n = 6'd38; 6'd53: n = 6'd31; 6'd54: n = 6'd39; 6'd55: n = 6'd46;
			6'd56: n = 6'd53; 6'd57: n = 6'd60; 6'd58: n = 6'd61; 6'd59: n = 6'd54;
			6'd60: n = 6'd47; 6'd61: n = 6'd55; 6'd62: n = 6'd62; 6'd63: n = 6'd63;
			default: n = 6'd0;
		endcase
		return n;
	endfunction

endpackage

FILE: hw/rtl/jpeg_huffman_block_decoder.sv
// jpeg baseline huffman block decoder: one dc and one ac table, 8x8 block decode
// usage: requests on item_valid/item_ready carry mode, table_sel, slot_index, payload.
// mode 0 loads a code count, mode 1 a symbol value.
// mode 3 restarts: clears the dc predictor and bit state, then builds canonical
// codes in a sweep (one code length per cycle) before the next request.
// mode 2 feeds one entropy-coded byte, msb first. the bits are shifted in one by
// one, and a bit that completes a huffman code is followed by a lookup step that
// uses the symbol read from memory; after the last bit a flush step hands off
// the byte's final result, if any, and returns to idle for the next request.
// results leave on result_valid/result_ready, up to eight per byte, the last one
// marked last_of_item. one result is held in a staging register and one in the
// output register; when the receiver stalls, decoding pauses while a result
// waits in staging and the output register cannot drain.
// reset clears the decode state, predictor and built codes; count and symbol
// tables hold nothing valid until loaded.
// depends on jhd_pkg, jhd_ctrl, jhd_datapath
module jpeg_huffman_block_decoder import jhd_pkg::*; #(
	parameter int MAX_SYMBOLS  = 256,
	parameter int MAX_CODE_LEN = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	jhd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.stat       (stat),
		.cmd        (cmd)
	);

	jhd_datapath #(
		.MAX_SYMBOLS  (MAX_SYMBOLS),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

FILE: hw/rtl/jhd_ctrl.sv
// controller state machine: request intake, bit sequencing, code build sweep, flush
// depends on jhd_pkg
module jhd_ctrl import jhd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  item_t    item,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_BIT   = 5'b00010,
		ST_LOOK  = 5'b00100,
		ST_BUILD = 5'b01000,
		ST_FLUSH = 5'b10000
	} state_t;

	state_t     state_q, state_d;
	logic [3:0] bits_left_q, bits_left_d;
	logic [4:0] bk_q, bk_d;
	logic       accept, stall;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	// a new result may only be made once the pending one has somewhere to go
	assign stall      = stat.pend_valid && !stat.out_free;

	always_comb begin
		state_d     = state_q;
		bits_left_d = bits_left_q;
		bk_d        = bk_q;
		cmd         = '0;
		cmd.build_k = bk_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (item.mode)
						MODE_COUNT:  cmd.wr_count = 1'b1;
						MODE_SYMBOL: cmd.wr_symbol = 1'b1;
						MODE_DATA: begin
							cmd.load_byte = 1'b1;
							bits_left_d   = 4'd8;
							state_d       = ST_BIT;
						end
						MODE_RESTART: begin
							cmd.restart = 1'b1;
							bk_d        = '0;
							state_d     = ST_BUILD;
						end
						default: ;
					endcase
				end
			end
			ST_BIT: begin
				if (!stall) begin
					cmd.bit_step = 1'b1;
					bits_left_d  = bits_left_q - 4'd1;
					if (stat.matched) begin
						state_d = ST_LOOK;
					end else if (bits_left_q == 4'd1) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_LOOK: begin
				if (!stall) begin
					cmd.look_step = 1'b1;
					state_d = (bits_left_q == 4'd0) ? ST_FLUSH : ST_BIT;
				end
			end
			ST_BUILD: begin
				cmd.build_step = 1'b1;
				bk_d = bk_q + 5'd1;
				if (bk_q == 5'd31) begin
					state_d = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (!stat.pend_valid) begin
					state_d = ST_IDLE;
				end else if (stat.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bits_left_q <= '0;
			bk_q        <= '0;
		end else begin
			state_q     <= state_d;
			bits_left_q <= bits_left_d;
			bk_q        <= bk_d;
		end
	end

`ifndef SYNTH
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_look_after_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOOK && $past(state_q) == ST_BIT |-> $past(stat.matched))
		else $error("lookup without a match");
	a_idle_after_build: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BUILD && bk_q == 5'd31 |=> state_q == ST_IDLE)
		else $error("build sweep overran");
`endif

endmodule

FILE: hw/rtl/jhd_datapath.sv
// datapath: tables, canonical code build, bit decoding, result staging
// depends on jhd_pkg; driven by jhd_ctrl
module jhd_datapath import jhd_pkg::*; #(
	parameter int MAX_SYMBOLS  = 256,
	parameter int MAX_CODE_LEN = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  item_t    item,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	output logic     result_valid,
	input  logic     result_ready,
	output result_t  result
);

	logic [7:0]  counts_q [32];
	logic [7:0]  sym_mem [512];
	logic [16:0] fc_q [32];
	logic [8:0]  fsi_q [32];

	logic [15:0] code_shift_q;
	logic [4:0]  code_len_q;
	phase_t      phase_q;
	logic [3:0]  vbits_q, vsize_q;
	logic [14:0] vshift_q;
	logic [6:0]  bp_q;
	logic [15:0] pred_q;
	logic [7:0]  byte_q;
	logic [16:0] acc_q;
	logic [8:0]  idx_q;
	logic [7:0]  sym_q;
	logic        pend_v_q, out_v_q;
	result_t     pend_q, out_q;

	// next-state values of the decode registers
	logic [15:0] code_shift_d;
	logic [4:0]  code_len_d;
	phase_t      phase_d;
	logic [3:0]  vbits_d, vsize_d;
	logic [14:0] vshift_d;
	logic [6:0]  bp_d;
	logic [15:0] pred_d;
	logic        res_v;
	result_t     res;

	logic        bit_in, sym_phase;
	logic [15:0] code_new;
	logic [4:0]  mk, ck;
	logic [7:0]  cnt;
	logic [16:0] fc, diff;
	logic [9:0]  si;
	logic        matched;
	logic [8:0]  sym_addr;
	logic [15:0] v16, half, ext, dc_sum;
	logic [3:0]  left_n;
	logic [3:0]  run;
	logic [6:0]  bpr;
	logic        out_free;

	assign bit_in    = byte_q[7];
	assign sym_phase = (phase_q == PH_DC_SYM) || (phase_q == PH_AC_SYM);
	assign code_new  = {code_shift_q[14:0], bit_in};
	assign mk        = {phase_q == PH_AC_SYM, code_len_q[3:0]};
	// one read port on the counts: build sweep or decode match
	assign ck        = cmd.build_step ? cmd.build_k : mk;
	assign cnt       = counts_q[ck];
	assign fc        = fc_q[mk];
	assign diff      = {1'b0, code_new} - fc;
	assign si        = {1'b0, fsi_q[mk]} + {2'b0, diff[7:0]};
	assign matched   = sym_phase && ({1'b0, code_new} >= fc) && (diff < {9'b0, cnt})
		&& (si < 10'(MAX_SYMBOLS));
	assign sym_addr  = {mk[4], si[7:0]};

	// sign extension of the value bits
	assign v16    = {vshift_q, bit_in};
	assign half   = 16'd1 << (vsize_q - 4'd1);
	assign ext    = (v16 < half) ? (v16 - ((16'd1 << vsize_q) - 16'd1)) : v16;
	assign dc_sum = pred_q + ext;
	assign left_n = (vbits_q != 4'd0) ? vbits_q - 4'd1 : 4'd0;
	assign run    = sym_q[7:4];
	assign bpr    = bp_q + {3'b0, run};

	always_comb begin
		code_shift_d = code_shift_q;
		code_len_d   = code_len_q;
		phase_d      = phase_q;
		vbits_d      = vbits_q;
		vsize_d      = vsize_q;
		vshift_d     = vshift_q;
		bp_d         = bp_q;
		pred_d       = pred_q;
		res_v        = 1'b0;
		res          = '0;
		if (cmd.bit_step) begin
			if (sym_phase) begin
				if (matched) begin
					code_shift_d = '0;
					code_len_d   = '0;
				end else if (code_len_q + 5'd1 >= 5'(MAX_CODE_LEN)) begin
					res_v        = 1'b1;
					res.kind     = KIND_NOMATCH;
					phase_d      = PH_DC_SYM;
					bp_d         = '0;
					code_shift_d = '0;
					code_len_d   = '0;
					vbits_d      = '0;
					vsize_d      = '0;
					vshift_d     = '0;
				end else begin
					code_shift_d = code_new;
					code_len_d   = code_len_q + 5'd1;
				end
			end else begin
				vshift_d = v16[14:0];
				vbits_d  = left_n;
				if (left_n == 4'd0) begin
					vshift_d = '0;
					res_v    = 1'b1;
					if (phase_q == PH_DC_VAL) begin
						pred_d          = dc_sum;
						res.kind        = KIND_COEFF;
						res.coeff_value = dc_sum;
						bp_d            = 7'd1;
						phase_d         = PH_AC_SYM;
					end else begin
						res.position    = natural_of(bp_q[5:0]);
						res.coeff_value = ext;
						if (bp_q + 7'd1 >= 7'(BLOCK_SIZE)) begin
							res.kind = KIND_CLOSE;
							phase_d  = PH_DC_SYM;
							bp_d     = '0;
							vsize_d  = '0;
						end else begin
							res.kind = KIND_COEFF;
							bp_d     = bp_q + 7'd1;
							phase_d  = PH_AC_SYM;
						end
					end
				end
			end
		end else if (cmd.look_step) begin
			if (phase_q == PH_DC_SYM) begin
				if (sym_q[3:0] == 4'd0) begin
					res_v           = 1'b1;
					res.kind        = KIND_COEFF;
					res.coeff_value = pred_q;
					bp_d            = 7'd1;
					phase_d         = PH_AC_SYM;
				end else begin
					vsize_d  = sym_q[3:0];
					vbits_d  = sym_q[3:0];
					vshift_d = '0;
					phase_d  = PH_DC_VAL;
				end
			end else if (sym_q == 8'd0) begin
				res_v        = 1'b1;
				res.kind     = KIND_EOB;
				res.position = natural_of(bp_q[5:0]);
				phase_d      = PH_DC_SYM;
				bp_d         = '0;
			end else if (bpr >= 7'(BLOCK_SIZE)) begin
				res_v    = 1'b1;
				res.kind = KIND_OVERRUN;
				phase_d  = PH_DC_SYM;
				bp_d     = '0;
			end else if (sym_q[3:0] == 4'd0) begin
				// zero run with no value, closes the block when it reaches the end
				if (bpr + 7'd1 >= 7'(BLOCK_SIZE)) begin
					res_v        = 1'b1;
					res.kind     = KIND_CLOSE;
					res.position = natural_of(bpr[5:0]);
					phase_d      = PH_DC_SYM;
					bp_d         = '0;
				end else begin
					bp_d = bpr + 7'd1;
				end
			end else begin
				bp_d     = bpr;
				vsize_d  = sym_q[3:0];
				vbits_d  = sym_q[3:0];
				vshift_d = '0;
				phase_d  = PH_AC_VAL;
			end
		end
		if (cmd.restart) begin
			phase_d      = PH_DC_SYM;
			bp_d         = '0;
			code_shift_d = '0;
			code_len_d   = '0;
			vbits_d      = '0;
			vsize_d      = '0;
			vshift_d     = '0;
			pred_d       = '0;
		end
	end

	// canonical code build, one length per cycle
	logic [16:0] a0, s1;
	logic [17:0] s2;
	logic [16:0] acc_n;
	logic [8:0]  i0, idx_n;
	logic        len_out;

	assign len_out = {1'b0, cmd.build_k[3:0]} >= 5'(MAX_CODE_LEN);
	assign a0      = (cmd.build_k[3:0] == 4'd0) ? '0 : acc_q;
	assign i0      = (cmd.build_k[3:0] == 4'd0) ? '0 : idx_q;
	assign s1      = ((a0 + {9'b0, cnt}) > NO_CODE) ? NO_CODE : a0 + {9'b0, cnt};
	assign s2      = {s1, 1'b0};
	assign acc_n   = (s2 > {1'b0, NO_CODE}) ? NO_CODE : s2[16:0];
	assign idx_n   = ((i0 + {1'b0, cnt}) > 9'(MAX_SYMBOLS)) ? 9'(MAX_SYMBOLS)
		: i0 + {1'b0, cnt};

	always_ff @(posedge clk) begin
		if (cmd.wr_count && item.slot_index < 8'(MAX_CODE_LEN)) begin
			counts_q[{item.table_sel, item.slot_index[3:0]}] <= item.payload;
		end
		if (cmd.wr_symbol && {1'b0, item.slot_index} < 9'(MAX_SYMBOLS)) begin
			sym_mem[{item.table_sel, item.slot_index}] <= item.payload;
		end
		if (cmd.bit_step && matched) begin
			sym_q <= sym_mem[sym_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 32; i++) begin
				fc_q[i]  <= '0;
				fsi_q[i] <= '0;
			end
			acc_q <= '0;
			idx_q <= '0;
		end else if (cmd.build_step) begin
			fc_q[cmd.build_k]  <= len_out ? NO_CODE : a0;
			fsi_q[cmd.build_k] <= len_out ? 9'(MAX_SYMBOLS) : i0;
			acc_q              <= acc_n;
			idx_q              <= idx_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_shift_q <= '0;
			code_len_q   <= '0;
			phase_q      <= PH_DC_SYM;
			vbits_q      <= '0;
			vsize_q      <= '0;
			vshift_q     <= '0;
			bp_q         <= '0;
			pred_q       <= '0;
		end else begin
			code_shift_q <= code_shift_d;
			code_len_q   <= code_len_d;
			phase_q      <= phase_d;
			vbits_q      <= vbits_d;
			vsize_q      <= vsize_d;
			vshift_q     <= vshift_d;
			bp_q         <= bp_d;
			pred_q       <= pred_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			byte_q <= item.payload;
		end else if (cmd.bit_step) begin
			byte_q <= {byte_q[6:0], 1'b0};
		end
	end

	// one result is held back so the last one of a byte can be marked
	assign out_free = !out_v_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (result_ready) begin
				out_v_q <= 1'b0;
			end
			if (res_v) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					out_v_q <= 1'b1;
				end
			end else if (cmd.flush) begin
				pend_v_q <= 1'b0;
				out_v_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_v) begin
			pend_q <= res;
			if (pend_v_q) begin
				out_q <= pend_q;
			end
		end else if (cmd.flush) begin
			// last_of_item is the low bit of the result
			out_q <= {pend_q[$bits(result_t)-1:1], 1'b1};
		end
	end

	assign result_valid    = out_v_q;
	assign result          = out_q;
	assign stat.matched    = matched;
	assign stat.pend_valid = pend_v_q;
	assign stat.out_free   = out_free;

`ifndef SYNTH
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_v && pend_v_q |-> out_free)
		else $error("result made while staging is full");
	a_flush_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> pend_v_q && out_free)
		else $error("flush without a pending result");
	a_code_len: assert property (@(posedge clk) disable iff (!arst_n)
		code_len_q < 5'(MAX_CODE_LEN))
		else $error("code length past limit");
	a_val_bits: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DC_VAL || phase_q == PH_AC_VAL |-> vbits_q != 4'd0)
		else $error("value phase with no bits left");
`endif

endmodule
